### rtl/ssd_pkg.sv
// shared types and constants for the segment-to-segment distance pipeline
// no dependencies
`timescale 1ns / 1ps

package ssd_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FIELD_W = 32;
	localparam int OUT_W = 32;

	typedef struct packed {
		logic signed [FIELD_W-1:0] seg_a_start_x;
		logic signed [FIELD_W-1:0] seg_a_start_y;
		logic signed [FIELD_W-1:0] seg_a_start_z;
		logic signed [FIELD_W-1:0] seg_a_end_x;
		logic signed [FIELD_W-1:0] seg_a_end_y;
		logic signed [FIELD_W-1:0] seg_a_end_z;
		logic signed [FIELD_W-1:0] seg_b_start_x;
		logic signed [FIELD_W-1:0] seg_b_start_y;
		logic signed [FIELD_W-1:0] seg_b_start_z;
		logic signed [FIELD_W-1:0] seg_b_end_x;
		logic signed [FIELD_W-1:0] seg_b_end_y;
		logic signed [FIELD_W-1:0] seg_b_end_z;
	} ssd_in_t;

	typedef struct packed {
		logic [OUT_W-1:0] gap_distance;
		logic             gap_saturated;
	} ssd_out_t;

endpackage

### rtl/ssd_if.sv
// valid/ready channel interfaces for segment pairs and distance results
// depends on ssd_pkg
`timescale 1ns / 1ps

interface ssd_in_if;
	logic             valid;
	logic             ready;
	ssd_pkg::ssd_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ssd_out_if;
	logic              valid;
	logic              ready;
	ssd_pkg::ssd_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/ssd_front.sv
// front end: coordinate capture, endpoint squared distances, choice of the endpoint of A
// depends on ssd_pkg
`timescale 1ns / 1ps

module ssd_front #(
	parameter int W = ssd_pkg::COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   item_valid,
	input  ssd_pkg::ssd_in_t       item,
	output logic                   result_valid,
	output logic [2:0][W-1:0]      pick,
	output logic [2:0][W-1:0]      a_start,
	output logic [2:0][W-1:0]      a_end,
	output logic [2:0][W-1:0]      b_start,
	output logic [2:0][W-1:0]      b_end
);
	import ssd_pkg::*;

	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int SW = 2 * W + 4;

	// point order: a start, a end, b start, b end
	logic [3:0][2:0][FIELD_W-1:0] raw;
	logic [3:0][2:0][W-1:0]       crd;
	logic [3:0][2:0][DW-1:0]      mg;

	logic                         v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [3:0][2:0][W-1:0]       pt_s1, pt_s2, pt_s3, pt_s4, pt_s5;
	logic [3:0][2:0][DW-1:0]      mg_s2;
	logic [3:0][2:0][PW-1:0]      sq_s3;
	logic [3:0][SW-1:0]           dsq_s4;
	logic [2:0][W-1:0]            pick_s5;
	logic                         take_start;

	assign raw[0] = {item.seg_a_start_z, item.seg_a_start_y, item.seg_a_start_x};
	assign raw[1] = {item.seg_a_end_z, item.seg_a_end_y, item.seg_a_end_x};
	assign raw[2] = {item.seg_b_start_z, item.seg_b_start_y, item.seg_b_start_x};
	assign raw[3] = {item.seg_b_end_z, item.seg_b_end_y, item.seg_b_end_x};

	for (genvar g = 0; g < 4; g++) begin : g_pt
		for (genvar k = 0; k < 3; k++) begin : g_ax
			if (W <= FIELD_W) begin : g_cut
				assign crd[g][k] = raw[g][k][W-1:0];
			end else begin : g_ext
				assign crd[g][k] = {{(W-FIELD_W){raw[g][k][FIELD_W-1]}}, raw[g][k]};
			end
		end
	end

	// pairs: b end - a end, b start - a end, b end - a start, b start - a start
	always_comb begin
		logic signed [DW-1:0] df;
		int bi;
		int ai;
		for (int j = 0; j < 4; j++) begin
			bi = (j % 2 == 0) ? 3 : 2;
			ai = (j < 2) ? 1 : 0;
			for (int k = 0; k < 3; k++) begin
				df = $signed({pt_s1[bi][k][W-1], pt_s1[bi][k]})
					- $signed({pt_s1[ai][k][W-1], pt_s1[ai][k]});
				mg[j][k] = df[DW-1] ? DW'(-df) : DW'(df);
			end
		end
	end

	assign take_start = (dsq_s4[2] < dsq_s4[0]) || (dsq_s4[2] < dsq_s4[1])
		|| (dsq_s4[3] < dsq_s4[0]) || (dsq_s4[3] < dsq_s4[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= crd;
			pt_s2 <= pt_s1;
			mg_s2 <= mg;
			pt_s3 <= pt_s2;
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 3; k++) begin
					sq_s3[j][k] <= PW'(mg_s2[j][k]) * PW'(mg_s2[j][k]);
				end
			end
			pt_s4 <= pt_s3;
			for (int j = 0; j < 4; j++) begin
				dsq_s4[j] <= SW'(sq_s3[j][0]) + SW'(sq_s3[j][1]) + SW'(sq_s3[j][2]);
			end
			pt_s5   <= pt_s4;
			pick_s5 <= take_start ? pt_s4[0] : pt_s4[1];
		end
	end

	assign result_valid = v_s5;
	assign pick         = pick_s5;
	assign a_start      = pt_s5[0];
	assign a_end        = pt_s5[1];
	assign b_start      = pt_s5[2];
	assign b_end        = pt_s5[3];

endmodule

### rtl/ssd_proj.sv
// clamped projection of a point onto a segment, rounded to the coordinate grid
// pipelined restoring divider, one quotient bit per stage; depends on ssd_pkg
`timescale 1ns / 1ps

module ssd_proj #(
	parameter int W   = ssd_pkg::COORD_WIDTH_DEF,
	parameter int SBW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              item_valid,
	input  logic [2:0][W-1:0] p,
	input  logic [2:0][W-1:0] s,
	input  logic [2:0][W-1:0] e,
	input  logic [SBW-1:0]    sb,
	output logic              result_valid,
	output logic [2:0][W-1:0] q,
	output logic [SBW-1:0]    q_sb
);
	import ssd_pkg::*;

	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int NW = 2 * W + 4;
	localparam int QW = W + 2;
	localparam int MW = QW + DW;
	localparam logic [NW-1:0] HALF = NW'(1) << (W + 1);

	typedef enum logic [1:0] {PICK_START, PICK_END, PICK_DIV} pick_t;

	logic                         v_s1, v_s2, v_s3, v_sm, v_sr;
	logic [2:0][W-1:0]            s_s1, s_s2, s_s3, s_sm, s_sr;
	logic [2:0][W-1:0]            e_s1, e_s2, e_s3, e_sm;
	logic [SBW-1:0]               sb_s1, sb_s2, sb_s3, sb_sm, sb_sr;
	logic signed [2:0][DW-1:0]    ps_s1, d_s1;
	logic [2:0][DW-1:0]           ad_s2, ad_s3;
	logic [2:0]                   neg_s2, neg_s3, neg_sm;
	logic [2:0][PW-1:0]           dd_s2, pd_s2;
	logic [2:0][PW-1:0]           dd, pd;
	logic [NW-1:0]                den_s3, num_s3;
	logic [2:0][MW-1:0]           prod_sm;
	pick_t                        mode_sm;
	logic [2:0][W-1:0]            q_sr;
	pick_t                        mode0;

	logic                         v_sd   [QW+1];
	logic [NW-1:0]                rem_sd [QW+1];
	logic [NW-1:0]                den_sd [QW+1];
	logic [QW-1:0]                u_sd   [QW+1];
	pick_t                        mode_sd[QW+1];
	logic [2:0][DW-1:0]           ad_sd  [QW+1];
	logic [2:0]                   neg_sd [QW+1];
	logic [2:0][W-1:0]            s_sd   [QW+1];
	logic [2:0][W-1:0]            e_sd   [QW+1];
	logic [SBW-1:0]               sb_sd  [QW+1];

	always_comb begin
		logic signed [PW-1:0] dx;
		logic signed [PW-1:0] px;
		for (int k = 0; k < 3; k++) begin
			dx    = PW'($signed(d_s1[k]));
			px    = PW'($signed(ps_s1[k]));
			dd[k] = dx * dx;
			pd[k] = px * dx;
		end
	end

	always_comb begin
		if (den_s3 == '0 || num_s3[NW-1] || num_s3 == '0) begin
			mode0 = PICK_START;
		end else if (num_s3 >= den_s3) begin
			mode0 = PICK_END;
		end else begin
			mode0 = PICK_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_sd[0]  <= 1'b0;
			v_sm     <= 1'b0;
			v_sr     <= 1'b0;
		end else if (en) begin
			v_s1     <= item_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_sd[0]  <= v_s3;
			v_sm     <= v_sd[QW];
			v_sr     <= v_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ps_s1[k] <= $signed({p[k][W-1], p[k]}) - $signed({s[k][W-1], s[k]});
				d_s1[k]  <= $signed({e[k][W-1], e[k]}) - $signed({s[k][W-1], s[k]});
			end
			s_s1  <= s;
			e_s1  <= e;
			sb_s1 <= sb;

			for (int k = 0; k < 3; k++) begin
				neg_s2[k] <= d_s1[k][DW-1];
				ad_s2[k]  <= d_s1[k][DW-1] ? DW'(-d_s1[k]) : DW'(d_s1[k]);
				dd_s2[k]  <= dd[k];
				pd_s2[k]  <= pd[k];
			end
			s_s2  <= s_s1;
			e_s2  <= e_s1;
			sb_s2 <= sb_s1;

			den_s3 <= NW'(dd_s2[0]) + NW'(dd_s2[1]) + NW'(dd_s2[2]);
			num_s3 <= {{2{pd_s2[0][PW-1]}}, pd_s2[0]} + {{2{pd_s2[1][PW-1]}}, pd_s2[1]}
				+ {{2{pd_s2[2][PW-1]}}, pd_s2[2]};
			ad_s3  <= ad_s2;
			neg_s3 <= neg_s2;
			s_s3   <= s_s2;
			e_s3   <= e_s2;
			sb_s3  <= sb_s2;

			rem_sd[0]  <= num_s3;
			den_sd[0]  <= den_s3;
			u_sd[0]    <= '0;
			mode_sd[0] <= mode0;
			ad_sd[0]   <= ad_s3;
			neg_sd[0]  <= neg_s3;
			s_sd[0]    <= s_s3;
			e_sd[0]    <= e_s3;
			sb_sd[0]   <= sb_s3;

			for (int k = 0; k < 3; k++) begin
				prod_sm[k] <= MW'(u_sd[QW]) * MW'(ad_sd[QW][k]);
			end
			mode_sm <= mode_sd[QW];
			neg_sm  <= neg_sd[QW];
			s_sm    <= s_sd[QW];
			e_sm    <= e_sd[QW];
			sb_sm   <= sb_sd[QW];

			for (int k = 0; k < 3; k++) begin
				case (mode_sm)
					PICK_END: q_sr[k] <= e_sm[k];
					PICK_DIV: q_sr[k] <= neg_sm[k]
						? W'({{2{s_sm[k][W-1]}}, s_sm[k]}
							- (({1'b0, prod_sm[k]} + HALF) >> QW))
						: W'({{2{s_sm[k][W-1]}}, s_sm[k]}
							+ (({1'b0, prod_sm[k]} + HALF) >> QW));
					default:  q_sr[k] <= s_sm[k];
				endcase
			end
			s_sr  <= s_sm;
			sb_sr <= sb_sm;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [NW:0] t;
		logic        ge;

		assign t  = {rem_sd[i], 1'b0};
		assign ge = t >= {1'b0, den_sd[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[i+1] <= 1'b0;
			end else if (en) begin
				v_sd[i+1] <= v_sd[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[i+1]  <= ge ? NW'(t - {1'b0, den_sd[i]}) : t[NW-1:0];
				u_sd[i+1]    <= {u_sd[i][QW-2:0], ge};
				den_sd[i+1]  <= den_sd[i];
				mode_sd[i+1] <= mode_sd[i];
				ad_sd[i+1]   <= ad_sd[i];
				neg_sd[i+1]  <= neg_sd[i];
				s_sd[i+1]    <= s_sd[i];
				e_sd[i+1]    <= e_sd[i];
				sb_sd[i+1]   <= sb_sd[i];
			end
		end
	end

	assign result_valid = v_sr;
	assign q            = q_sr;
	assign q_sb         = sb_sr;

endmodule

### rtl/ssd_sqrt.sv
// distance between two points: squared sum, pipelined integer square root,
// rounding and saturation to the output field; depends on ssd_pkg
`timescale 1ns / 1ps

module ssd_sqrt #(
	parameter int W = ssd_pkg::COORD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              item_valid,
	input  logic [2:0][W-1:0] a,
	input  logic [2:0][W-1:0] b,
	output logic              result_valid,
	output ssd_pkg::ssd_out_t result
);
	import ssd_pkg::*;

	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int RW = W + 2;
	localparam int NW = 2 * RW;
	localparam int GW = RW + OUT_W;

	logic                  v_s1, v_s2, v_sr;
	logic [2:0][DW-1:0]    mg_s1;
	logic [2:0][PW-1:0]    sq_s2;
	ssd_out_t              res_sr;
	logic [2:0][DW-1:0]    mg;
	logic [RW-1:0]         g;
	logic [GW-1:0]         g_w;
	logic                  sat;

	logic                  v_sq  [RW+1];
	logic [NW-1:0]         op_sq [RW+1];
	logic [NW-1:0]         rt_sq [RW+1];

	always_comb begin
		logic signed [DW-1:0] df;
		for (int k = 0; k < 3; k++) begin
			df    = $signed({a[k][W-1], a[k]}) - $signed({b[k][W-1], b[k]});
			mg[k] = df[DW-1] ? DW'(-df) : DW'(df);
		end
	end

	assign g   = rt_sq[RW][RW-1:0] + RW'(op_sq[RW] > rt_sq[RW]);
	assign g_w = GW'(g);
	assign sat = |g_w[GW-1:OUT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_sq[0]  <= 1'b0;
			v_sr     <= 1'b0;
		end else if (en) begin
			v_s1     <= item_valid;
			v_s2     <= v_s1;
			v_sq[0]  <= v_s2;
			v_sr     <= v_sq[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mg_s1 <= mg;
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= PW'(mg_s1[k]) * PW'(mg_s1[k]);
			end
			op_sq[0] <= NW'(sq_s2[0]) + NW'(sq_s2[1]) + NW'(sq_s2[2]);
			rt_sq[0] <= '0;
			res_sr.gap_saturated <= sat;
			res_sr.gap_distance  <= sat ? '1 : g_w[OUT_W-1:0];
		end
	end

	// v_s2 qualifies sq_s2, whose squared sum is loaded into root stage zero
	for (genvar i = 0; i < RW; i++) begin : g_root
		localparam logic [NW-1:0] ONE = NW'(1) << (2 * (RW - 1 - i));
		logic [NW-1:0] trial;
		logic          ge;

		assign trial = rt_sq[i] + ONE;
		assign ge    = op_sq[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[i+1] <= 1'b0;
			end else if (en) begin
				v_sq[i+1] <= v_sq[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				op_sq[i+1] <= ge ? op_sq[i] - trial : op_sq[i];
				rt_sq[i+1] <= ge ? (rt_sq[i] >> 1) + ONE : rt_sq[i] >> 1;
			end
		end
	end

	assign result_valid = v_sr;
	assign result       = res_sr;

endmodule

### rtl/segment_segment_distance.sv
// approximate closest distance between two 3D segments, one segment pair per clock while not stalled
// depends on ssd_pkg, ssd_if, ssd_front, ssd_proj, ssd_sqrt
`timescale 1ns / 1ps
//
// usage:
//   pair : sink channel, one transaction carries both endpoints of segments A and B,
//          signed fixed point, only the low COORD_WIDTH bits of each field are used
//   gap  : source channel, one transaction per pair with the rounded distance
//          and a flag set when the distance saturates to all ones
//   order of results matches order of pairs, exactly one result per pair
// structure: the two projection dividers and the square root each resolve
//   one result bit per stage
// throughput: one pair per cycle, pair.ready stays high while the receiver keeps up
// stall: the output register and a one-entry skid register absorb a held gap.ready;
//   the pipeline freezes only once the skid register is full, nothing is dropped
// reset: arst_n clears all valid bits; no item is in flight afterwards
//
module segment_segment_distance #(
	parameter int COORD_WIDTH = ssd_pkg::COORD_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ssd_in_if.sink      pair,
	ssd_out_if.source   gap
);
	import ssd_pkg::*;

	localparam int W = COORD_WIDTH;

	logic              en;
	logic              fr_v, p1_v, p2_v, sq_v;
	logic [2:0][W-1:0] pick, a_start, a_end, b_start, b_end;
	logic [2:0][W-1:0] qb, ra, qb2, a_start1, a_end1;
	logic [6*W-1:0]    sb1;
	logic [3*W-1:0]    sb2;
	ssd_out_t          sq_res;
	logic              out_v_q, skid_v_q;
	ssd_out_t          out_q, skid_q;

	assign en         = !skid_v_q;
	assign pair.ready = en;

	ssd_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .item_valid(pair.valid), .item(pair.data),
		.result_valid(fr_v), .pick(pick), .a_start(a_start), .a_end(a_end),
		.b_start(b_start), .b_end(b_end)
	);

	ssd_proj #(.W(W), .SBW(6 * W)) u_proj_b (
		.clk(clk), .arst_n(arst_n), .en(en), .item_valid(fr_v),
		.p(pick), .s(b_start), .e(b_end), .sb({a_end, a_start}),
		.result_valid(p1_v), .q(qb), .q_sb(sb1)
	);

	assign a_start1 = sb1[3*W-1:0];
	assign a_end1   = sb1[6*W-1:3*W];

	ssd_proj #(.W(W), .SBW(3 * W)) u_proj_a (
		.clk(clk), .arst_n(arst_n), .en(en), .item_valid(p1_v),
		.p(qb), .s(a_start1), .e(a_end1), .sb(qb),
		.result_valid(p2_v), .q(ra), .q_sb(sb2)
	);

	assign qb2 = sb2;

	ssd_sqrt #(.W(W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .item_valid(p2_v),
		.a(ra), .b(qb2), .result_valid(sq_v), .result(sq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_v_q || gap.ready) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || gap.ready) begin
			out_v_q <= sq_v;
		end else if (sq_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_v_q || gap.ready) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || gap.ready) begin
			out_q <= sq_res;
		end else if (sq_v) begin
			skid_q <= sq_res;
		end
	end

	assign gap.valid = out_v_q;
	assign gap.data  = out_q;

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a result while the output is empty");

	a_skid_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !gap.ready) |=> skid_v_q)
		else $error("skid result dropped during a stall");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(gap.valid && gap.data.gap_saturated) |-> (gap.data.gap_distance == '1))
		else $error("saturated distance is not all ones");

endmodule

### sim/tb_segment_segment_distance.sv
// self-checking testbench for segment_segment_distance: random and directed segment pairs
// depends on ssd_pkg, ssd_if and the segment_segment_distance rtl
`timescale 1ns / 1ps

class gap_scoreboard;
	ssd_pkg::ssd_out_t expected_gaps[$];
	int mismatches;

	static function longint signed coord(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	static function logic [127:0] sq_len(longint signed p[3], longint signed q[3]);
		logic [127:0] acc;
		logic [127:0] d;
		acc = 0;
		for (int k = 0; k < 3; k++) begin
			d = (p[k] >= q[k]) ? 128'(p[k] - q[k]) : 128'(q[k] - p[k]);
			acc += d * d;
		end
		return acc;
	endfunction

	static function void clamp_project(longint signed p[3], longint signed s[3],
			longint signed e[3], output longint signed o[3]);
		logic signed [129:0] num;
		logic signed [129:0] den;
		logic [127:0] ratio;
		logic [127:0] mag;
		logic [127:0] t;
		longint signed d[3];
		num = 0;
		den = 0;
		for (int k = 0; k < 3; k++) begin
			d[k] = e[k] - s[k];
			den += 130'(d[k]) * 130'(d[k]);
			num += 130'(p[k] - s[k]) * 130'(d[k]);
		end
		if (den == 0 || num <= 0) begin
			o = s;
			return;
		end
		if (num >= den) begin
			o = e;
			return;
		end
		ratio = 128'(((num <<< 34) / den));
		for (int k = 0; k < 3; k++) begin
			mag = (d[k] < 0) ? 128'(-d[k]) : 128'(d[k]);
			t = (ratio * mag + (128'd1 << 33)) >> 34;
			o[k] = (d[k] < 0) ? s[k] - longint'(t) : s[k] + longint'(t);
		end
	endfunction

	static function ssd_pkg::ssd_out_t predict_gap(ssd_pkg::ssd_in_t x);
		longint signed as[3], ae[3], bs[3], be[3], pick[3], qb[3], ra[3];
		logic [127:0] d0, d1, d2, d3, sq, rem;
		logic [63:0] root, c;
		ssd_pkg::ssd_out_t r;
		as = '{coord(x.seg_a_start_x), coord(x.seg_a_start_y), coord(x.seg_a_start_z)};
		ae = '{coord(x.seg_a_end_x), coord(x.seg_a_end_y), coord(x.seg_a_end_z)};
		bs = '{coord(x.seg_b_start_x), coord(x.seg_b_start_y), coord(x.seg_b_start_z)};
		be = '{coord(x.seg_b_end_x), coord(x.seg_b_end_y), coord(x.seg_b_end_z)};
		d0 = sq_len(be, ae);
		d1 = sq_len(bs, ae);
		d2 = sq_len(be, as);
		d3 = sq_len(bs, as);
		pick = (d2 < d0 || d2 < d1 || d3 < d0 || d3 < d1) ? as : ae;
		clamp_project(pick, bs, be, qb);
		clamp_project(qb, as, ae, ra);
		sq = sq_len(ra, qb);
		root = 0;
		for (int b = 63; b >= 0; b--) begin
			c = root | (64'd1 << b);
			if (128'(c) * 128'(c) <= sq)
				root = c;
		end
		rem = sq - 128'(root) * 128'(root);
		if (rem > 128'(root))
			root++;
		if (root > 64'hFFFF_FFFF) begin
			r.gap_distance = '1;
			r.gap_saturated = 1'b1;
		end else begin
			r.gap_distance = root[31:0];
			r.gap_saturated = 1'b0;
		end
		return r;
	endfunction

	function void note_pair(ssd_pkg::ssd_in_t x);
		expected_gaps.push_back(predict_gap(x));
	endfunction

	function void check_gap(ssd_pkg::ssd_out_t got);
		ssd_pkg::ssd_out_t want;
		if (expected_gaps.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected gap transaction %h", got);
			return;
		end
		want = expected_gaps.pop_front();
		if (got.gap_distance !== want.gap_distance || got.gap_saturated !== want.gap_saturated) begin
			mismatches++;
			if (mismatches <= 10)
				$display("gap mismatch: expected %h/%b got %h/%b", want.gap_distance,
					want.gap_saturated, got.gap_distance, got.gap_saturated);
		end
	endfunction
endclass

module tb_segment_segment_distance;
	import ssd_pkg::*;

	localparam int LATENCY = 3 * 32 + 28;
	localparam int IDLE_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic stall_on;
	int idle_cycles;
	int stall_phase;
	gap_scoreboard sb;

	ssd_in_if pair();
	ssd_out_if gap();

	segment_segment_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair),
		.gap(gap)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && gap.valid && gap.ready)
			sb.check_gap(gap.data);
		if (arst_n && pair.valid && pair.ready)
			sb.note_pair(pair.data);
		if ((pair.valid && pair.ready) || (gap.valid && gap.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stall pattern, with quiet stretches
	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase % 2000 < 400)
			gap.ready <= 1'b1;
		else if (stall_on)
			gap.ready <= ($urandom_range(0, 3) != 0);
		else
			gap.ready <= ((stall_phase % 7) < 4);
		if (stall_phase % 500 == 0)
			stall_on <= ~stall_on;
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			3: return 32'($signed($urandom_range(0, 200000)) - 100000);
			default: return $urandom;
		endcase
	endfunction

	function automatic ssd_in_t rand_pair();
		ssd_in_t x;
		x = {12{32'h0}};
		for (int i = 0; i < 12; i++)
			x[i*32 +: 32] = rand_coord();
		case ($urandom_range(0, 5))
			0: {x.seg_a_end_x, x.seg_a_end_y, x.seg_a_end_z} =
				{x.seg_a_start_x, x.seg_a_start_y, x.seg_a_start_z};
			1: {x.seg_b_end_x, x.seg_b_end_y, x.seg_b_end_z} =
				{x.seg_b_start_x, x.seg_b_start_y, x.seg_b_start_z};
			default: ;
		endcase
		return x;
	endfunction

	task automatic send_pair(ssd_in_t x);
		pair.data <= x;
		pair.valid <= 1'b1;
		do @(posedge clk); while (!pair.ready);
		@(negedge clk);
	endtask

	task automatic pause_sender(int cycles);
		pair.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		pair.valid <= 1'b0;
		while (sb.expected_gaps.size() != 0) @(negedge clk);
	endtask

	initial begin
		ssd_in_t x;
		int burst;
		sb = new();
		arst_n = 1'b0;
		pair.valid = 1'b0;
		pair.data = '0;
		gap.ready = 1'b0;
		stall_on = 1'b0;
		stall_phase = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extremes, degenerate segments, crossing and parallel cases
		send_pair('0);
		send_pair({12{32'h8000_0000}});
		send_pair({12{32'h7FFF_FFFF}});
		send_pair({{6{32'h8000_0000}}, {6{32'h7FFF_FFFF}}});
		send_pair({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}},
			{3{32'h8000_0000}}});
		send_pair({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}},
			{3{32'h7FFF_FFFF}}});
		send_pair({{3{32'hFFFF_FFFF}}, {3{32'h0001_0000}}, {3{32'h0}}, {3{32'h0}}});
		send_pair({32'hFFF6_0000, 32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'h0,
			32'h0, 32'hFFF6_0000, 32'h0003_0000, 32'h0, 32'h000A_0000, 32'h0003_0000});
		send_pair({32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0, 32'h0,
			32'h0002_0000, 32'h0005_0000, 32'h0, 32'h0008_0000, 32'h0005_0000, 32'h0});
		send_pair({32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
			32'h0005_0000, 32'h0005_0000, 32'h0, 32'h0009_0000, 32'h0002_0000, 32'h0});
		send_pair({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
		drain();

		for (int n = 0; n < 1250; ) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++) begin
				x = rand_pair();
				send_pair(x);
				n++;
			end
			if (n > 600 && n < 650)
				drain();
			else if ($urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 12));
		end
		drain();
		repeat (LATENCY + 20) @(negedge clk);
		if (sb.mismatches == 0 && sb.expected_gaps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
